// ----- design/cl_pkg.sv -----
`default_nettype none
package cl_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W   = 18;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned QTR_N    = 257;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_FILT,
    ST_ARM,
    ST_PROD,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mix;
    logic filt_clear;
    logic filt_step;
    logic arm;
    logic prod;
    logic update;
  } cl_cmd_t;

  typedef struct packed {
    logic filt_done;
  } cl_status_t;

  // Quarter-wave sine, round(32767*sin(pi/2*q/256)).
  function automatic logic [15:0] quarter_sine(input logic [8:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x = (64'(q) * 64'd3373259426) / 64'd512;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  // The series is evaluated once at elaboration; entry q sits at bits [16*q +: 16].
  function automatic logic [QTR_N*16-1:0] quarter_table();
    logic [QTR_N*16-1:0] t;
    t = '0;
    for (int q = 0; q < QTR_N; q++) t[16*q +: 16] = quarter_sine(9'(q));
    return t;
  endfunction

  localparam logic [QTR_N*16-1:0] QTR_TABLE = quarter_table();

endpackage
`default_nettype wire

// ----- design/cl_ctrl.sv -----
`default_nettype none
module cl_ctrl
  import cl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       out_free,
  input  wire cl_status_t status,
  output cl_cmd_t         cmd,
  output logic            busy,
  output logic            out_load
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_MIX;
      ST_MIX:    state_next = ST_FILT;
      ST_FILT:   if (status.filt_done) state_next = ST_ARM;
      ST_ARM:    state_next = ST_PROD;
      ST_PROD:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:   busy = 1'b0;
      ST_MIX:    begin cmd.mix = 1'b1; cmd.filt_clear = 1'b1; end
      ST_FILT:   cmd.filt_step = 1'b1;
      ST_ARM:    cmd.arm = 1'b1;
      ST_PROD:   cmd.prod = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_OUT:    out_load = out_free;
      default:   busy = 1'b1;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> state == ST_MIX)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> state == ST_OUT)
    else $error("update not followed by output");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mix, cmd.filt_step, cmd.arm, cmd.prod, cmd.update}))
    else $error("commands overlap");

endmodule
`default_nettype wire

// ----- design/cl_datapath.sv -----
`default_nettype none
module cl_datapath
  import cl_pkg::*;
#(
  parameter int unsigned NUM_TAPS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cl_cmd_t                    cmd,
  output cl_status_t                      status,
  input  wire logic                       tap_we,
  input  wire logic [5:0]                 tap_index,
  input  wire logic signed [SAMPLE_W-1:0] tap_value,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [PHASE_W-1:0]         phase_step,
  input  wire logic [GAIN_W-1:0]          loop_gain,
  output logic signed [SAMPLE_W-1:0]      baseband,
  output logic [PHASE_W-1:0]              phase_correction
);

  localparam int unsigned PW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int unsigned CW = $clog2(NUM_TAPS + 1);
  localparam int unsigned ACC_W = PROD_W + SAMPLE_W + CW + 1;

  logic signed [PROD_W-1:0]   sin_line [NUM_TAPS];
  logic signed [PROD_W-1:0]   cos_line [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] taps [NUM_TAPS];
  logic [PW-1:0]              wptr;
  logic [PHASE_W-1:0]         nco_phase;
  logic [PHASE_W-1:0]         phase_offset;
  logic [CW-1:0]              k;
  logic signed [ACC_W-1:0]    acc_s, acc_c;
  logic signed [SAMPLE_W-1:0] a_sin, a_cos;
  logic signed [2*SAMPLE_W-1:0] arm_prod;
  logic signed [2*SAMPLE_W+GAIN_W:0] gain_prod;

  logic [PHASE_W-1:0] carrier;
  logic [9:0]  idx_s, idx_c;
  logic signed [SAMPLE_W-1:0] sn, cs;
  logic signed [2*SAMPLE_W-1:0] mul_s, mul_c;

  function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [9:0] i);
    logic [8:0]  j;
    logic [15:0] v;
    j = {1'b0, i[7:0]};
    if (i[8]) j = 9'd256 - j;
    v = QTR_TABLE[16*j +: 16];
    return i[9] ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_arm(
    input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + ACC_W'(16384)) >>> 15;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[SAMPLE_W-1:0];
  endfunction

  assign carrier = nco_phase + phase_offset;
  assign idx_s = carrier[PHASE_W-1 -: 10];
  assign idx_c = idx_s + 10'd256;
  assign sn = sine_at(idx_s);
  assign cs = sine_at(idx_c);
  assign mul_s = sample * sn;
  assign mul_c = sample * cs;

  // Step k pairs line slot (wptr + k), oldest first, with tap NUM_TAPS-1-k.
  logic [PW-1:0] pos;
  logic [PW-1:0] tap_sel;
  always_comb begin
    pos = PW'((CW+1)'(wptr) + (CW+1)'(k)) ;
    if ({1'b0, wptr} + k >= NUM_TAPS) pos = PW'({1'b0, wptr} + k - NUM_TAPS);
    tap_sel = PW'(NUM_TAPS - 1 - k);
  end

  assign status.filt_done = (k == CW'(NUM_TAPS));

  always_ff @(posedge clk) begin
    if (tap_we && tap_index < NUM_TAPS) taps[tap_index[PW-1:0]] <= tap_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        sin_line[i] <= '0;
        cos_line[i] <= '0;
      end
      wptr <= '0;
      nco_phase <= '0;
      phase_offset <= '0;
      k <= '0;
    end else begin
      if (cmd.mix) begin
        sin_line[wptr] <= mul_s[14 +: PROD_W];
        cos_line[wptr] <= mul_c[14 +: PROD_W];
        wptr <= (wptr == PW'(NUM_TAPS - 1)) ? '0 : wptr + 1'b1;
        nco_phase <= nco_phase + phase_step;
      end
      if (cmd.filt_clear) k <= '0;
      else if (cmd.filt_step && !status.filt_done) k <= k + 1'b1;
      if (cmd.update) phase_offset <= phase_offset - gain_prod[16 +: PHASE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.filt_clear) begin
      acc_s <= '0;
      acc_c <= '0;
    end else if (cmd.filt_step && !status.filt_done) begin
      acc_s <= acc_s + ACC_W'(sin_line[pos] * taps[tap_sel]);
      acc_c <= acc_c + ACC_W'(cos_line[pos] * taps[tap_sel]);
    end
    if (cmd.arm) begin
      a_sin <= sat_arm(acc_s);
      a_cos <= sat_arm(acc_c);
    end
    if (cmd.prod) arm_prod <= a_sin * a_cos;
  end

  assign gain_prod = arm_prod * $signed({1'b0, loop_gain});
  assign baseband = a_cos;
  assign phase_correction = phase_offset;

  assert property (@(posedge clk) disable iff (rst)
    cmd.mix |=> k == '0)
    else $error("filter counter not cleared");
  assert property (@(posedge clk) disable iff (rst)
    cmd.mix |=> wptr != $past(wptr) || NUM_TAPS == 1)
    else $error("write pointer stuck");
  assert property (@(posedge clk) disable iff (rst)
    !cmd.update && !$past(rst) |=> $stable(phase_offset) || $past(cmd.update))
    else $error("phase offset changed outside update");

endmodule
`default_nettype wire

// ----- design/costas_loop_carrier_recovery.sv -----
// BPSK Costas loop carrier recovery.
// s_axis carries items: operation 0 mixes one IF sample, operation 1 loads one
// low-pass tap and gives no result. m_axis carries one result per sample: the
// filtered cosine arm (baseband) and the phase correction after the update.
// phase_step (address 0) and loop_gain (address 4) sit on the APB port and are
// to be written by the user only while the block is idle; the block does not enforce it.
// From acceptance to m_tvalid a sample passes through one mix step, NUM_TAPS
// multiply-accumulate steps of the shared FIR unit plus one step to see the
// count finish, then rounding, the arm product, the phase update and the output
// load. A new sample is taken only once the last result is loaded for output;
// the FIR loop sets the rate. A tap load is taken only while the block is idle.
// While a sample is being processed, or its result waits for the previous one
// to leave the output register, s_tready stays low for every item. Taps must be
// loaded before samples; they are not cleared by reset.
// Reset clears delay lines, NCO phase, phase correction, the APB registers and m_tvalid.
`default_nettype none
module costas_loop_carrier_recovery
  import cl_pkg::*;
#(
  parameter int unsigned NUM_TAPS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // sample[15:0], tap_index[21:16], tap_value[37:22]
  input  wire logic        s_tuser,  // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // baseband[15:0], phase_correction[47:16]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [PHASE_W-1:0] phase_step;
  logic [GAIN_W-1:0]  loop_gain;
  cl_cmd_t    cmd;
  cl_status_t status;
  logic busy, out_load, accept, is_load, start;
  logic signed [SAMPLE_W-1:0] sample_reg;
  logic signed [SAMPLE_W-1:0] baseband;
  logic [PHASE_W-1:0] phase_correction;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      loop_gain <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) phase_step <= pwdata;
      else if (paddr == 3'd4) loop_gain <= pwdata[GAIN_W-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = phase_step;
    else if (paddr == 3'd4) prdata = {16'd0, loop_gain};
  end

  // Loads also wait for idle so that taps never change under a running filter.
  assign is_load = (op_t'(s_tuser) == OP_LOAD);
  assign s_tready = !busy;
  assign accept = s_tvalid && s_tready;
  assign start = accept && !is_load;

  always_ff @(posedge clk) begin
    if (start) sample_reg <= $signed(s_tdata[15:0]);
  end

  cl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .out_free(!m_tvalid || m_tready),
    .status(status), .cmd(cmd), .busy(busy), .out_load(out_load)
  );

  cl_datapath #(.NUM_TAPS(NUM_TAPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .tap_we(accept && is_load), .tap_index(s_tdata[21:16]),
    .tap_value($signed(s_tdata[37:22])), .sample(sample_reg),
    .phase_step(phase_step), .loop_gain(loop_gain),
    .baseband(baseband), .phase_correction(phase_correction)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {phase_correction, baseband};
  end

  assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("sample taken while busy");

endmodule
`default_nettype wire

// ----- verif/tb_costas_loop_carrier_recovery.sv -----
`default_nettype none
module tb_costas_loop_carrier_recovery;
  import cl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS = 32;
  localparam int REG_PHASE_STEP = 0;
  localparam int REG_LOOP_GAIN = 1;
  localparam int SETTLE_CYCLES = NTAPS + 20;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    op_t op;
    logic signed [15:0] sample;
    logic [5:0] tap_index;
    logic signed [15:0] tap_value;
  } item_t;

  typedef struct {
    logic [15:0] baseband;
    logic [31:0] correction;
  } carrier_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  costas_loop_carrier_recovery u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Loop model state.
  logic signed [15:0] qwave [0:256];
  logic signed [17:0] sin_line [NTAPS];
  logic signed [17:0] cos_line [NTAPS];
  logic signed [15:0] lpf_taps [NTAPS];
  int unsigned line_ptr;
  logic [31:0] nco_acc;
  logic [31:0] phase_corr;
  logic [31:0] nco_step;
  logic [15:0] gain;

  item_t pending_items[$];
  carrier_result_t expected_results[$];
  item_t cur_item;
  int errors = 0;
  int results_seen = 0;

  function automatic void build_qwave();
    logic [63:0] x, x2, term;
    logic signed [63:0] acc, v;
    for (int q = 0; q <= 256; q++) begin
      x = (64'(q) * 64'd3373259426) / 64'd512;
      x2 = (x * x) >> 30;
      term = x;
      acc = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      v = (acc * 32767 + 64'sd536870912) >>> 30;
      if (v > 32767) v = 32767;
      qwave[q] = v[15:0];
    end
  endfunction

  function automatic logic signed [15:0] table_sine(logic [9:0] idx);
    logic [7:0] j;
    j = idx[7:0];
    case (idx[9:8])
      2'd0: return qwave[j];
      2'd1: return qwave[256 - j];
      2'd2: return -qwave[j];
      default: return -qwave[256 - j];
    endcase
  endfunction

  function automatic logic signed [15:0] filter_arm(ref logic signed [17:0] line [NTAPS]);
    logic signed [63:0] acc;
    logic signed [63:0] r;
    acc = 0;
    for (int k = 0; k < NTAPS; k++)
      acc += 64'(line[(line_ptr + k) % NTAPS]) * 64'(lpf_taps[NTAPS - 1 - k]);
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void track_item(item_t it);
    logic [9:0] idx;
    logic signed [31:0] prod;
    logic signed [15:0] a_sin, a_cos;
    logic signed [63:0] delta;
    carrier_result_t res;
    if (it.op == OP_LOAD) begin
      if (it.tap_index < NTAPS) lpf_taps[it.tap_index] = it.tap_value;
      return;
    end
    idx = 10'((nco_acc + phase_corr) >> 22);
    prod = 32'(it.sample) * 32'(table_sine(idx));
    sin_line[line_ptr] = 18'(prod >>> 14);
    prod = 32'(it.sample) * 32'(table_sine(idx + 10'd256));
    cos_line[line_ptr] = 18'(prod >>> 14);
    line_ptr = (line_ptr + 1) % NTAPS;
    a_sin = filter_arm(sin_line);
    a_cos = filter_arm(cos_line);
    delta = (64'(a_sin) * 64'(a_cos) * $signed({48'd0, gain})) >>> 16;
    phase_corr = phase_corr - delta[31:0];
    nco_acc = nco_acc + nco_step;
    res.baseband = a_cos;
    res.correction = phase_corr;
    expected_results = {expected_results, res};
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nxt_valid;
    item_t nxt;
    nxt_valid = s_tvalid;
    nxt = cur_item;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        track_item(cur_item);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      cur_item <= nxt;
      s_tvalid <= nxt_valid;
      s_tuser <= nxt.op;
      s_tdata <= {2'b00, nxt.tap_value, nxt.tap_index, nxt.sample};
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off to back up the block.
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && results_seen == 120) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    carrier_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result: baseband %h correction %h", m_tdata[15:0], m_tdata[47:16]);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[15:0] !== want.baseband) begin
          $error("baseband expected %h actual %h", want.baseband, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[47:16] !== want.correction) begin
          $error("phase_correction expected %h actual %h", want.correction, m_tdata[47:16]);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(int index, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_PHASE_STEP) nco_step = value;
    else if (index == REG_LOOP_GAIN) gain = value[15:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_load(int index, logic signed [15:0] value);
    item_t it;
    it.op = OP_LOAD;
    it.sample = 16'($urandom);
    it.tap_index = 6'(index);
    it.tap_value = value;
    pending_items = {pending_items, it};
  endtask

  task automatic push_sample(logic signed [15:0] value);
    item_t it;
    it.op = OP_SAMPLE;
    it.sample = value;
    it.tap_index = 6'($urandom);
    it.tap_value = 16'($urandom);
    pending_items = {pending_items, it};
  endtask

  task automatic random_items(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) push_load($urandom_range(0, 63), 16'($urandom));
      else if (pick < 14) push_sample(16'sh7FFF);
      else if (pick < 18) push_sample(-16'sh8000);
      else push_sample(16'($urandom));
    end
  endtask

  initial begin
    build_qwave();
    foreach (sin_line[i]) begin
      sin_line[i] = '0;
      cos_line[i] = '0;
      lpf_taps[i] = '0;
    end
    line_ptr = 0;
    nco_acc = '0;
    phase_corr = '0;
    nco_step = '0;
    gain = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: every tap written before any sample, extremes of both fields.
    reg_write(REG_PHASE_STEP, 32'h0123_4567);
    reg_write(REG_LOOP_GAIN, 16'hFFFF);
    for (int i = 0; i < NTAPS; i++) begin
      if (i == 0) push_load(i, -16'sh8000);
      else if (i == 1) push_load(i, 16'sh7FFF);
      else push_load(i, 16'($urandom_range(0, 4095)));
    end
    push_load(63, 16'sh7FFF);
    push_load(32, -16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(-16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'sh7FFF);
    push_sample(-16'sh0001);
    wait_drained();

    reg_write(REG_PHASE_STEP, 32'h0);
    reg_write(REG_LOOP_GAIN, 16'h0);
    random_items(280);
    wait_drained();

    reg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
    reg_write(REG_LOOP_GAIN, 16'hFFFF);
    random_items(280);
    wait_drained();

    for (int p = 0; p < 2; p++) begin
      reg_write(REG_PHASE_STEP, $urandom);
      reg_write(REG_LOOP_GAIN, 16'($urandom));
      random_items(280);
      wait_drained();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
design/cl_pkg.sv
design/cl_ctrl.sv
design/cl_datapath.sv
design/costas_loop_carrier_recovery.sv
verif/tb_costas_loop_carrier_recovery.sv
